// File: src/keyboard_reset_line_sequencer_defines.svh
// Assertion helpers for the reset line sequencer.
`ifndef KEYBOARD_RESET_LINE_SEQUENCER_DEFINES_SVH
`define KEYBOARD_RESET_LINE_SEQUENCER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset.
`define KLRS_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define KLRS_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");

`else

`define KLRS_ASSERT_IMPLY(label, clk, rst, lhs, rhs)
`define KLRS_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// File: src/klrs_pkg.sv
package klrs_pkg;

   // Countdown width in bits.
   localparam int CountBits = 12;
   localparam int MsBits    = 12;
   localparam int ExtBits   = (CountBits > MsBits) ? CountBits : MsBits;

   // Configuration port
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits  = MsBits;

   localparam logic [CsrIndexBits-1:0] CsrPowerTracking = 3'd0;
   localparam logic [CsrIndexBits-1:0] CsrPowerOnDelay  = 3'd1;
   localparam logic [CsrIndexBits-1:0] CsrShortReset    = 3'd2;
   localparam logic [CsrIndexBits-1:0] CsrShortLines    = 3'd3;
   localparam logic [CsrIndexBits-1:0] CsrLongReset     = 3'd4;

   localparam logic [MsBits-1:0] PowerOnDelayRst = 12'd400;
   localparam logic [MsBits-1:0] ShortResetRst   = 12'd400;
   localparam logic [MsBits-1:0] ShortLinesRst   = 12'd500;
   localparam logic [MsBits-1:0] LongResetRst    = 12'd2500;

   // Transaction kinds
   localparam logic FuncPoll    = 1'b0;
   localparam logic FuncCommand = 1'b1;

   // Power states; code three behaves like off
   localparam logic [1:0] PowerInit = 2'd0;
   localparam logic [1:0] PowerOn   = 2'd1;
   localparam logic [1:0] PowerOff  = 2'd2;

   // Reset line actions
   localparam logic [1:0] ResetNone    = 2'd0;
   localparam logic [1:0] ResetLow     = 2'd1;
   localparam logic [1:0] ResetRelease = 2'd2;

   // Keyboard line actions
   localparam logic [1:0] LinesNone = 2'd0;
   localparam logic [1:0] LinesLow  = 2'd1;
   localparam logic [1:0] LinesHigh = 2'd2;

   localparam logic [ExtBits-1:0] CountMax = ExtBits'({CountBits{1'b1}});

   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      logic              power_tracking_on;
      logic [MsBits-1:0] power_on_delay_ms;
      logic [MsBits-1:0] short_reset_ms;
      logic [MsBits-1:0] short_lines_ms;
      logic [MsBits-1:0] long_reset_ms;
   } cfg_type;

   typedef struct packed {
      logic       func;
      logic [1:0] power_now;
      logic       pin_low;
      logic       hold;
      logic       long_reset;
   } req_item_type;

   typedef struct packed {
      logic [1:0] reset_drive;
      logic [1:0] lines_drive;
      logic       report_valid;
      logic       report_in_reset;
      logic       believed_in_reset;
   } rsp_item_type;

   // Millisecond setting to countdown load value, saturating at the counter top
   function automatic count_type load_count(input logic [MsBits-1:0] ms);
      logic [ExtBits-1:0] ext;
      ext = ExtBits'(ms);
      if (ext > CountMax) begin
         return CountMax[CountBits-1:0];
      end
      return ext[CountBits-1:0];
   endfunction

endpackage

// File: src/klrs_chan_if.sv
// Input channel: poll or reset command transactions
interface klrs_req_if import klrs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       func;
   logic [1:0] power_now;
   logic       pin_low;
   logic       hold;
   logic       long_reset;

   modport source (output valid, func, power_now, pin_low, hold, long_reset, input ready);
   modport sink   (input valid, func, power_now, pin_low, hold, long_reset, output ready);
endinterface

// Result channel: one transaction per input transaction
interface klrs_rsp_if import klrs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] reset_drive;
   logic [1:0] lines_drive;
   logic       report_valid;
   logic       report_in_reset;
   logic       believed_in_reset;

   modport source (output valid, reset_drive, lines_drive, report_valid, report_in_reset,
                   believed_in_reset, input ready);
   modport sink   (input valid, reset_drive, lines_drive, report_valid, report_in_reset,
                   believed_in_reset, output ready);
endinterface

// File: src/klrs_csr.sv
// Configuration registers, write only
module klrs_csr import klrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CsrPowerTracking: cfg_in.power_tracking_on = csr_wdata[0];
            CsrPowerOnDelay:  cfg_in.power_on_delay_ms = csr_wdata;
            CsrShortReset:    cfg_in.short_reset_ms    = csr_wdata;
            CsrShortLines:    cfg_in.short_lines_ms    = csr_wdata;
            CsrLongReset:     cfg_in.long_reset_ms     = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.power_tracking_on <= 1'b1;
         cfg_ff.power_on_delay_ms <= PowerOnDelayRst;
         cfg_ff.short_reset_ms    <= ShortResetRst;
         cfg_ff.short_lines_ms    <= ShortLinesRst;
         cfg_ff.long_reset_ms     <= LongResetRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/klrs_core.sv
// Sequencer state and the per-transaction update
module klrs_core import klrs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   count_type  rel_cnt_ff, rel_cnt_in;
   logic       rel_armed_ff, rel_armed_in;
   count_type  lines_cnt_ff, lines_cnt_in;
   logic       lines_armed_ff, lines_armed_in;
   logic       belief_ff, belief_in;
   logic       known_ff, known_in;
   logic [1:0] prior_power_ff, prior_power_in;
   logic       prior_pin_ff, prior_pin_in;

   // Next state and result for the transaction at hand
   always_comb begin
      rel_cnt_in     = rel_cnt_ff;
      rel_armed_in   = rel_armed_ff;
      lines_cnt_in   = lines_cnt_ff;
      lines_armed_in = lines_armed_ff;
      belief_in      = belief_ff;
      known_in       = known_ff;
      prior_power_in = prior_power_ff;
      prior_pin_in   = prior_pin_ff;
      result         = '0;

      if (item.func == FuncCommand) begin
         result.reset_drive = ResetLow;
         result.lines_drive = LinesLow;
         if (item.hold) begin
            rel_armed_in   = 1'b0;
            lines_armed_in = 1'b0;
            rel_cnt_in     = '0;
            lines_cnt_in   = '0;
         end else if (item.long_reset) begin
            rel_cnt_in     = load_count(cfg.long_reset_ms);
            lines_cnt_in   = load_count(cfg.long_reset_ms);
            rel_armed_in   = 1'b1;
            lines_armed_in = 1'b1;
         end else begin
            rel_cnt_in     = load_count(cfg.short_reset_ms);
            lines_cnt_in   = load_count(cfg.short_lines_ms);
            rel_armed_in   = 1'b1;
            lines_armed_in = 1'b1;
         end
      end else begin
         // Millisecond tick
         if (rel_armed_ff && (rel_cnt_ff != '0)) begin
            rel_cnt_in = rel_cnt_ff - 1'b1;
         end
         if (lines_armed_ff && (lines_cnt_ff != '0)) begin
            lines_cnt_in = lines_cnt_ff - 1'b1;
         end

         if (item.power_now != PowerInit) begin
            if (!known_ff) begin
               belief_in = item.pin_low;
               known_in  = 1'b1;
            end
            // Keyboard line countdown
            if (lines_armed_ff && (lines_cnt_in == '0)) begin
               lines_armed_in     = 1'b0;
               result.lines_drive = LinesHigh;
            end
            // Power transitions
            if (cfg.power_tracking_on && (item.power_now != prior_power_ff)) begin
               if (item.power_now == PowerOn) begin
                  if (belief_in) begin
                     rel_cnt_in   = load_count(cfg.power_on_delay_ms);
                     rel_armed_in = 1'b1;
                  end
               end else if (!belief_in) begin
                  result.reset_drive = ResetLow;
                  belief_in          = 1'b1;
               end
               prior_power_in = item.power_now;
            end
            // Reset release countdown
            if (rel_armed_in && (rel_cnt_in == '0)) begin
               rel_armed_in       = 1'b0;
               result.reset_drive = ResetRelease;
               belief_in          = 1'b0;
            end
            // Pin change report
            if (item.pin_low != prior_pin_ff) begin
               prior_pin_in = item.pin_low;
               if (item.power_now == PowerOn) begin
                  result.report_valid    = 1'b1;
                  result.report_in_reset = item.pin_low;
               end
            end
         end
      end

      result.believed_in_reset = belief_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rel_cnt_ff     <= '0;
         rel_armed_ff   <= 1'b0;
         lines_cnt_ff   <= '0;
         lines_armed_ff <= 1'b0;
         belief_ff      <= 1'b0;
         known_ff       <= 1'b0;
         prior_power_ff <= PowerInit;
         prior_pin_ff   <= 1'b0;
      end else if (step) begin
         rel_cnt_ff     <= rel_cnt_in;
         rel_armed_ff   <= rel_armed_in;
         lines_cnt_ff   <= lines_cnt_in;
         lines_armed_ff <= lines_armed_in;
         belief_ff      <= belief_in;
         known_ff       <= known_in;
         prior_power_ff <= prior_power_in;
         prior_pin_ff   <= prior_pin_in;
      end
   end

endmodule

// File: src/keyboard_reset_line_sequencer.sv
// Keyboard reset line sequencer.
// req_chan carries one transaction per millisecond poll (power state and
// sampled reset pin) or per reset command (hold / long select). rsp_chan
// returns exactly one transaction for each, in order: reset line action,
// keyboard line action, pin change report and the current in-reset belief.
// csr_we / csr_index / csr_wdata write the five settings; write them only
// while no transaction is in flight.
// A transaction accepted on req_chan is registered in the input register,
// evaluated against the sequencer state, and its result is registered in
// the result register, which drives rsp_chan.
// Throughput: one transaction per cycle while rsp_chan is not stalled; the
// state update is a single pass of countdown decrement and compare between
// the input register and the result register.
// Reset clears both countdowns, the belief and the remembered power and
// pin, and loads the settings with their defaults; no transaction is held.
// When the receiver stalls, the result register holds its transaction and
// the input register takes one more; req_chan.ready drops only when both
// are full.
`include "keyboard_reset_line_sequencer_defines.svh"

module keyboard_reset_line_sequencer import klrs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   klrs_req_if.sink                req_chan,
   klrs_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CsrDataBits-1:0]  csr_wdata
);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type in_item_ff;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type result;
   rsp_item_type out_item_ff;
   logic         out_valid_ff, out_valid_in;
   logic         out_free;
   logic         step;
   logic         req_take;

   klrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline flow control
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign req_item.func       = req_chan.func;
   assign req_item.power_now  = req_chan.power_now;
   assign req_item.pin_low    = req_chan.pin_low;
   assign req_item.hold       = req_chan.hold;
   assign req_item.long_reset = req_chan.long_reset;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_item_ff <= req_item;
      end
   end

   klrs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (step) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.reset_drive       = out_item_ff.reset_drive;
   assign rsp_chan.lines_drive       = out_item_ff.lines_drive;
   assign rsp_chan.report_valid      = out_item_ff.report_valid;
   assign rsp_chan.report_in_reset   = out_item_ff.report_in_reset;
   assign rsp_chan.believed_in_reset = out_item_ff.believed_in_reset;

   // Checks
   `KLRS_ASSERT_IMPLY(a_report_level_gated, clock, reset,
      out_valid_ff && out_item_ff.report_in_reset, out_item_ff.report_valid)
   `KLRS_ASSERT_IMPLY(a_release_clears_belief, clock, reset,
      out_valid_ff && (out_item_ff.reset_drive == ResetRelease),
      !out_item_ff.believed_in_reset)
   `KLRS_ASSERT_IMPLY(a_full_blocks_input, clock, reset,
      in_valid_ff && !out_free, !req_chan.ready)
   `KLRS_ASSERT_NEXT(a_step_fills_output, clock, reset, step, out_valid_ff)

endmodule

// File: verif/keyboard_reset_line_sequencer_test.sv
module keyboard_reset_line_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import klrs_pkg::*;

   // Power code three has no name in the package; it acts like off
   localparam logic [1:0] PowerOther = 2'd3;
   localparam int QuietLimit = 5000;
   localparam int ItemTarget = 600;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0] csr_wdata;

   klrs_req_if req_chan ();
   klrs_rsp_if rsp_chan ();

   keyboard_reset_line_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow settings
   logic              track_power;
   logic [MsBits-1:0] on_delay;
   logic [MsBits-1:0] short_rst;
   logic [MsBits-1:0] short_kbd;
   logic [MsBits-1:0] long_rst;

   // Shadow sequencer state
   count_type  rel_cnt;
   count_type  kbd_cnt;
   logic       rel_on;
   logic       kbd_on;
   logic       believe_reset;
   logic       belief_valid;
   logic [1:0] last_power;
   logic       last_pin;

   req_item_type pending_items[$];
   rsp_item_type expected_actions[$];
   req_item_type in_flight;

   int  errors;
   int  items_queued;
   int  idle_left;
   int  stall_left;
   int  quiet_cycles;
   bit  gaps_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Millisecond setting to countdown load, saturating at the counter top
   function automatic count_type to_count(input logic [MsBits-1:0] ms);
      if (longint'(ms) > longint'((64'd1 << CountBits) - 64'd1)) begin
         return '1;
      end
      return count_type'(ms);
   endfunction

   // Expected line actions for one transaction; advances the shadow state
   function automatic rsp_item_type advance_sequencer(input req_item_type t);
      rsp_item_type r;
      r = '0;
      if (t.func == FuncCommand) begin
         r.reset_drive = ResetLow;
         r.lines_drive = LinesLow;
         if (t.hold) begin
            rel_on = 1'b0;
            kbd_on = 1'b0;
            rel_cnt = '0;
            kbd_cnt = '0;
         end else if (t.long_reset) begin
            rel_cnt = to_count(long_rst);
            kbd_cnt = to_count(long_rst);
            rel_on = 1'b1;
            kbd_on = 1'b1;
         end else begin
            rel_cnt = to_count(short_rst);
            kbd_cnt = to_count(short_kbd);
            rel_on = 1'b1;
            kbd_on = 1'b1;
         end
      end else begin
         if (rel_on && rel_cnt != 0) rel_cnt = rel_cnt - 1'b1;
         if (kbd_on && kbd_cnt != 0) kbd_cnt = kbd_cnt - 1'b1;
         // initial power only counts down
         if (t.power_now != PowerInit) begin
            if (!belief_valid) begin
               believe_reset = t.pin_low;
               belief_valid = 1'b1;
            end
            if (kbd_on && kbd_cnt == 0) begin
               kbd_on = 1'b0;
               r.lines_drive = LinesHigh;
            end
            if (track_power && t.power_now != last_power) begin
               if (t.power_now == PowerOn) begin
                  if (believe_reset) begin
                     rel_cnt = to_count(on_delay);
                     rel_on = 1'b1;
                  end
               end else if (!believe_reset) begin
                  r.reset_drive = ResetLow;
                  believe_reset = 1'b1;
               end
               last_power = t.power_now;
            end
            // release wins over a power-off assertion in the same poll
            if (rel_on && rel_cnt == 0) begin
               rel_on = 1'b0;
               r.reset_drive = ResetRelease;
               believe_reset = 1'b0;
            end
            if (t.pin_low != last_pin) begin
               last_pin = t.pin_low;
               if (t.power_now == PowerOn) begin
                  r.report_valid = 1'b1;
                  r.report_in_reset = t.pin_low;
               end
            end
         end
      end
      r.believed_in_reset = believe_reset;
      return r;
   endfunction

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic req_item_type poll_item(input logic [1:0] pw, input logic pin);
      req_item_type t;
      t.func = FuncPoll;
      t.power_now = pw;
      t.pin_low = pin;
      t.hold = 1'($urandom_range(0, 1));
      t.long_reset = 1'($urandom_range(0, 1));
      return t;
   endfunction

   function automatic req_item_type cmd_item(input logic hold, input logic lng);
      req_item_type t;
      t.func = FuncCommand;
      t.power_now = 2'($urandom_range(0, 3));
      t.pin_low = 1'($urandom_range(0, 1));
      t.hold = hold;
      t.long_reset = lng;
      return t;
   endfunction

   function automatic logic [1:0] pick_power();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return PowerOn;
      if (r < 8) return PowerOff;
      if (r == 8) return PowerOther;
      return PowerInit;
   endfunction

   // Poll run outlasting the current countdowns when all are at most 20; else 1 to 24
   function automatic int settle_len();
      logic [MsBits-1:0] d;
      d = on_delay;
      if (short_rst > d) d = short_rst;
      if (short_kbd > d) d = short_kbd;
      if (long_rst > d) d = long_rst;
      if (d <= 20) return int'(d) + $urandom_range(1, 3);
      return $urandom_range(1, 24);
   endfunction

   function automatic logic [MsBits-1:0] pick_delay();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return 12'd1;
      if (r == 2) return 12'd4095;
      return MsBits'($urandom_range(2, 8));
   endfunction

   task automatic queue_item(input req_item_type t);
      pending_items.push_back(t);
      items_queued++;
   endtask

   // One well-formed sequence with random content, or a burst of noise
   task automatic add_scenario();
      int kind;
      int len;
      logic [1:0] pw;
      logic pin;
      kind = $urandom_range(0, 9);
      pin = 1'($urandom_range(0, 1));
      if (kind <= 2) begin
         pw = pick_power();
         len = $urandom_range(1, 10);
         repeat (len) begin
            if ($urandom_range(0, 7) == 0) pin = ~pin;
            queue_item(poll_item(pw, pin));
         end
      end else if (kind <= 4) begin
         // power cycle: off, then on with the pin held low for all but the last two polls
         repeat ($urandom_range(1, 4)) queue_item(poll_item(PowerOff, 1'b1));
         len = settle_len();
         for (int i = 0; i < len; i++) begin
            queue_item(poll_item(PowerOn, i < len - 2));
         end
      end else if (kind <= 6) begin
         // commanded reset or hold followed by on polls, pin low for the first half
         queue_item(cmd_item($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1))));
         len = settle_len();
         for (int i = 0; i < len; i++) begin
            queue_item(poll_item(PowerOn, i < len / 2));
         end
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 4)) queue_item(poll_item(PowerInit, 1'($urandom_range(0, 1))));
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 4)) queue_item(poll_item(PowerOther, 1'($urandom_range(0, 1))));
      end else begin
         repeat ($urandom_range(1, 6)) begin
            queue_item(req_item_type'(6'($urandom_range(0, 63))));
         end
      end
   endtask

   // Settings writes; shadow follows once the write edge has passed
   task automatic write_setting(input logic [CsrIndexBits-1:0] idx,
                                input logic [CsrDataBits-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrPowerTracking: track_power = val[0];
         CsrPowerOnDelay:  on_delay = val;
         CsrShortReset:    short_rst = val;
         CsrShortLines:    short_kbd = val;
         CsrLongReset:     long_rst = val;
         default: ;
      endcase
   endtask

   task automatic write_all(input logic trk, input logic [MsBits-1:0] pod,
                            input logic [MsBits-1:0] srs, input logic [MsBits-1:0] sln,
                            input logic [MsBits-1:0] lrs);
      write_setting(CsrPowerTracking, {11'($urandom_range(0, 2047)), trk});
      write_setting(CsrPowerOnDelay, pod);
      write_setting(CsrShortReset, srs);
      write_setting(CsrShortLines, sln);
      write_setting(CsrLongReset, lrs);
   endtask

   // Block is idle once nothing is queued, driven or outstanding
   task automatic wait_idle();
      @(negedge clock);
      while (pending_items.size() != 0 || req_chan.valid || expected_actions.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Stimulus and phase control
   initial begin
      int phase;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.func = FuncPoll;
      req_chan.power_now = PowerInit;
      req_chan.pin_low = 1'b0;
      req_chan.hold = 1'b0;
      req_chan.long_reset = 1'b0;
      rsp_chan.ready = 1'b0;
      errors = 0;
      items_queued = 0;
      idle_left = 0;
      stall_left = 0;
      gaps_on = 1'b1;
      track_power = 1'b1;
      on_delay = PowerOnDelayRst;
      short_rst = ShortResetRst;
      short_kbd = ShortLinesRst;
      long_rst = LongResetRst;
      rel_cnt = '0;
      kbd_cnt = '0;
      rel_on = 1'b0;
      kbd_on = 1'b0;
      believe_reset = 1'b0;
      belief_valid = 1'b0;
      last_power = PowerInit;
      last_pin = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: default settings
      queue_item(poll_item(PowerInit, 1'b1));
      queue_item(poll_item(PowerInit, 1'b0));
      queue_item(poll_item(PowerOn, 1'b1));
      queue_item(poll_item(PowerOn, 1'b1));
      queue_item(cmd_item(1'b1, 1'b0));
      queue_item(cmd_item(1'b0, 1'b0));
      queue_item(cmd_item(1'b0, 1'b1));
      queue_item(cmd_item(1'b1, 1'b1));
      queue_item(poll_item(PowerOther, 1'b0));
      queue_item(poll_item(PowerOff, 1'b1));
      queue_item(poll_item(PowerOn, 1'b1));
      queue_item(poll_item(PowerOff, 1'b0));
      queue_item(poll_item(PowerOn, 1'b0));
      queue_item(poll_item(PowerInit, 1'b1));

      // Directed: zero delays, so countdowns fire at once
      wait_idle();
      write_all(1'b1, '0, '0, '0, '0);
      @(negedge clock);
      queue_item(poll_item(PowerOff, 1'b1));
      queue_item(poll_item(PowerOn, 1'b1));
      queue_item(cmd_item(1'b0, 1'b0));
      queue_item(poll_item(PowerInit, 1'b1));
      queue_item(poll_item(PowerOn, 1'b0));
      queue_item(cmd_item(1'b0, 1'b1));
      queue_item(poll_item(PowerOff, 1'b1));

      // Largest delays: a long command and a short run of polls
      wait_idle();
      write_all(1'b1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
      @(negedge clock);
      queue_item(cmd_item(1'b0, 1'b1));
      repeat (20) queue_item(poll_item(PowerOn, 1'b1));
      queue_item(poll_item(PowerOn, 1'b0));

      // Random phases
      phase = 0;
      while (items_queued < ItemTarget) begin
         wait_idle();
         gaps_on = (phase % 4) != 3;
         if (phase == 0) begin
            write_all(1'b0, 12'd3, 12'd2, 12'd4, 12'd5);
         end else if (phase == 1) begin
            write_all(1'b1, 12'd1, 12'd1, 12'd1, 12'd1);
         end else begin
            write_all($urandom_range(0, 4) != 0, pick_delay(), pick_delay(), pick_delay(),
                      pick_delay());
         end
         if ($urandom_range(0, 3) == 0) begin
            write_setting(CsrIndexBits'($urandom_range(5, 7)), MsBits'($urandom_range(0, 4095)));
         end
         @(negedge clock);
         repeat (8) add_scenario();
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Driver: one transaction from the pending queue, then a random gap
   always @(posedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) expected_actions.push_back(advance_sequencer(in_flight));
         if (idle_left > 0) begin
            idle_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            nxt = pending_items.pop_front();
            in_flight = nxt;
            req_chan.func <= nxt.func;
            req_chan.power_now <= nxt.power_now;
            req_chan.pin_low <= nxt.pin_low;
            req_chan.hold <= nxt.hold;
            req_chan.long_reset <= nxt.long_reset;
            req_chan.valid <= 1'b1;
            idle_left = pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Monitor: random back-pressure and in-order compare
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_actions.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d/%0d/%0d",
                        $time, rsp_chan.reset_drive, rsp_chan.lines_drive,
                        rsp_chan.report_valid, rsp_chan.report_in_reset,
                        rsp_chan.believed_in_reset);
               errors++;
            end else begin
               want = expected_actions.pop_front();
               check_field("reset_drive", want.reset_drive, rsp_chan.reset_drive);
               check_field("lines_drive", want.lines_drive, rsp_chan.lines_drive);
               check_field("report_valid", want.report_valid, rsp_chan.report_valid);
               check_field("report_in_reset", want.report_in_reset, rsp_chan.report_in_reset);
               check_field("believed_in_reset", want.believed_in_reset,
                           rsp_chan.believed_in_reset);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Watchdog on cycles without any transaction or settings write
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: sim.f
+incdir+src
src/klrs_pkg.sv
src/klrs_chan_if.sv
src/klrs_csr.sv
src/klrs_core.sv
src/keyboard_reset_line_sequencer.sv
verif/keyboard_reset_line_sequencer_test.sv
